// ----- rtl/core/fsf_pkg.sv -----
`default_nettype none
package fsf_pkg;

    localparam logic [2:0] KIND_FMT     = 3'd0;
    localparam logic [2:0] KIND_STR     = 3'd1;
    localparam logic [2:0] KIND_STR_END = 3'd2;
    localparam logic [2:0] KIND_NULL    = 3'd3;
    localparam logic [2:0] KIND_FMT_END = 3'd4;

    localparam logic [7:0] CHAR_PCT   = 8'h25;
    localparam logic [7:0] CHAR_MINUS = 8'h2d;
    localparam logic [7:0] CHAR_D     = 8'h64;
    localparam logic [7:0] CHAR_X     = 8'h78;
    localparam logic [7:0] CHAR_S     = 8'h73;

    localparam int          COUNT_W   = 31;
    localparam logic [30:0] COUNT_MAX = 31'h7fff_ffff;
    localparam logic [2:0]  NULL_LAST = 3'd5;

    typedef enum logic [2:0] {
        SRC_INPUT,
        SRC_PCT,
        SRC_MINUS,
        SRC_NULL,
        SRC_DIGIT,
        SRC_COUNT
    } t_src;

    typedef struct packed {
        logic       load;
        logic       hex;
        logic       step;
        logic       shift;
        logic       emit;
        t_src       src;
        logic [2:0] null_idx;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic out_free;
        logic top_zero;
        logic neg;
    } t_status;

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        logic [7:0] c;
        unique case (d)
            4'h0: c = 8'h30;
            4'h1: c = 8'h31;
            4'h2: c = 8'h32;
            4'h3: c = 8'h33;
            4'h4: c = 8'h34;
            4'h5: c = 8'h35;
            4'h6: c = 8'h36;
            4'h7: c = 8'h37;
            4'h8: c = 8'h38;
            4'h9: c = 8'h39;
            4'ha: c = 8'h61;
            4'hb: c = 8'h62;
            4'hc: c = 8'h63;
            4'hd: c = 8'h64;
            4'he: c = 8'h65;
            4'hf: c = 8'h66;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] null_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h28;
            3'd1:    c = 8'h6e;
            3'd2:    c = 8'h75;
            3'd3:    c = 8'h6c;
            3'd4:    c = 8'h6c;
            3'd5:    c = 8'h29;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/format_string_formatter.sv -----
`default_nettype none
// Streaming printf-style formatter for the s, d and x conversions.
// Input channel s_axis: one request per format byte, string byte, string end,
// null string or format end; the kind travels in tuser.
// Output channel m_axis: one result per emitted character, or one count-only
// result at a format end (tuser has_char low); tlast marks the final result
// of a request.
// A request is taken only when the sequencer is idle. A plain byte is accepted
// in idle, then emitted from the S_CHAR state into the output register; the
// next request is taken in the same cycle that the byte shows up, so no new
// byte is taken before the last one is in the output register. A decimal
// conversion passes through the binary-to-BCD unit (four bits a cycle), emits
// a minus sign when negative, skips the leading zero digits, then prints one
// digit per result; hex skips the BCD pass and the sign.
// Reset returns to plain byte mode, clears the character count and empties
// the output register.
// A stalled receiver holds the output register; the sequencer waits and
// takes no new request until its results are all loaded.
module format_string_formatter #(
    parameter int NUMBER_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // char_in[7:0], number[39:8]
    input  wire logic [2:0]  s_axis_tuser,   // kind[2:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // char_out[7:0], total_count[38:8], zero[39]
    output logic [0:0]       m_axis_tuser,   // has_char[0]
    output logic             m_axis_tlast
);
    import fsf_pkg::*;

    t_cmd        w_cmd;
    t_status     w_status;
    logic [7:0]  w_char;
    logic        w_has_char;
    logic        w_last;
    logic [30:0] w_total;

    fsf_ctrl #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_kind   (s_axis_tuser),
        .i_char   (s_axis_tdata[7:0]),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    fsf_datapath #(
        .NUMBER_WIDTH (NUMBER_WIDTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_char     (s_axis_tdata[7:0]),
        .i_number   (s_axis_tdata[39:8]),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_char     (w_char),
        .o_has_char (w_has_char),
        .o_last     (w_last),
        .o_total    (w_total)
    );

    assign m_axis_tdata = {1'b0, w_total, w_char};
    assign m_axis_tuser = w_has_char;
    assign m_axis_tlast = w_last;

endmodule
`default_nettype wire

// ----- rtl/core/fsf_datapath.sv -----
`default_nettype none
module fsf_datapath #(
    parameter int NUMBER_WIDTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire fsf_pkg::t_cmd      i_cmd,
    output fsf_pkg::t_status        o_status,
    input  wire logic [7:0]         i_char,
    input  wire logic [31:0]        i_number,
    input  wire logic               i_m_tready,
    output logic                    o_m_tvalid,
    output logic [7:0]              o_char,
    output logic                    o_has_char,
    output logic                    o_last,
    output logic [30:0]             o_total
);
    import fsf_pkg::*;

    localparam int NW   = NUMBER_WIDTH;
    localparam int NHEX = (NW + 3) / 4;
    localparam int NDEC = ((NW - 1) * 30103) / 100000 + 1;
    localparam int DIG  = (NDEC > NHEX) ? NDEC : NHEX;
    localparam int MW   = 4 * NHEX;
    localparam int DW   = 4 * DIG;

    logic [7:0]         r_ch;
    logic [DW-1:0]      r_dig;
    logic [MW-1:0]      r_mag;
    logic               r_neg;
    logic [COUNT_W-1:0] r_count;
    logic               r_out_valid;
    logic [7:0]         r_out_char;
    logic               r_out_has;
    logic               r_out_last;
    logic [COUNT_W-1:0] r_out_total;

    logic [63:0]        w_sx;
    logic [NW-1:0]      w_bits;
    logic [NW-1:0]      w_abs;
    logic [DW-1:0]      w_step_dig;
    logic [MW-1:0]      w_step_mag;
    logic [3:0]         w_top;
    logic [7:0]         w_char;
    logic [COUNT_W-1:0] w_inc;
    logic               w_free;

    assign w_sx   = {{32{i_number[31]}}, i_number};
    assign w_bits = w_sx[NW-1:0];
    assign w_abs  = w_bits[NW-1] ? (~w_bits + NW'(1)) : w_bits;
    assign w_top  = r_dig[DW-1 -: 4];
    assign w_free = !r_out_valid || i_m_tready;
    assign w_inc  = (r_count == COUNT_MAX) ? r_count : r_count + COUNT_W'(1);

    always_comb begin : dabble
        logic [DW-1:0] b;
        logic [MW-1:0] m;
        b = r_dig;
        m = r_mag;
        for (int s = 0; s < 4; s++) begin
            for (int d = 0; d < DIG; d++) begin
                if (b[4*d +: 4] >= 4'd5) begin
                    b[4*d +: 4] = b[4*d +: 4] + 4'd3;
                end
            end
            b = {b[DW-2:0], m[MW-1]};
            m = {m[MW-2:0], 1'b0};
        end
        w_step_dig = b;
        w_step_mag = m;
    end

    always_comb begin
        unique case (i_cmd.src)
            SRC_INPUT: w_char = r_ch;
            SRC_PCT:   w_char = CHAR_PCT;
            SRC_MINUS: w_char = CHAR_MINUS;
            SRC_NULL:  w_char = null_char(i_cmd.null_idx);
            SRC_DIGIT: w_char = hex_char(w_top);
            SRC_COUNT: w_char = 8'd0;
            default:   w_char = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ch  <= i_char;
            r_mag <= MW'(w_abs);
            r_neg <= w_bits[NW-1];
            r_dig <= i_cmd.hex ? DW'(w_bits) : '0;
        end else if (i_cmd.step) begin
            r_dig <= w_step_dig;
            r_mag <= w_step_mag;
        end else if (i_cmd.shift) begin
            r_dig <= {r_dig[DW-5:0], 4'd0};
        end
        if (i_cmd.emit) begin
            r_out_char  <= w_char;
            r_out_has   <= (i_cmd.src != SRC_COUNT);
            r_out_last  <= i_cmd.last;
            r_out_total <= (i_cmd.src == SRC_COUNT) ? r_count : w_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_count     <= (i_cmd.src == SRC_COUNT) ? '0 : w_inc;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.out_free = w_free;
    assign o_status.top_zero = (w_top == 4'd0);
    assign o_status.neg      = r_neg;

    assign o_m_tvalid = r_out_valid;
    assign o_char     = r_out_char;
    assign o_has_char = r_out_has;
    assign o_last     = r_out_last;
    assign o_total    = r_out_total;

endmodule
`default_nettype wire

// ----- rtl/core/fsf_ctrl.sv -----
`default_nettype none
module fsf_ctrl #(
    parameter int NUMBER_WIDTH = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [2:0]        i_kind,
    input  wire logic [7:0]        i_char,
    input  wire fsf_pkg::t_status  i_status,
    output fsf_pkg::t_cmd          o_cmd
);
    import fsf_pkg::*;

    localparam int NW   = NUMBER_WIDTH;
    localparam int NHEX = (NW + 3) / 4;
    localparam int NDEC = ((NW - 1) * 30103) / 100000 + 1;
    localparam int DIG  = (NDEC > NHEX) ? NDEC : NHEX;
    localparam int CW   = $clog2(DIG + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHAR,
        S_PCT,
        S_COUNT,
        S_NULL,
        S_CONV,
        S_SIGN,
        S_SKIP,
        S_DIGIT
    } t_state;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_PCT,
        MODE_STR
    } t_mode;

    t_state        r_state, n_state;
    t_mode         r_mode, n_mode;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [2:0]    r_idx, n_idx;
    logic          r_pct_count, n_pct_count;
    logic          w_accept;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = o_ready && i_valid;

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_pct_count = r_pct_count;
        o_cmd       = '0;
        o_cmd.src   = SRC_INPUT;
        o_cmd.null_idx = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    o_cmd.load = 1'b1;
                    o_cmd.hex  = (i_char == CHAR_X);
                    if (r_mode == MODE_STR) begin
                        if (i_kind == KIND_STR) begin
                            n_state = S_CHAR;
                        end else if (i_kind == KIND_STR_END) begin
                            n_mode = MODE_IDLE;
                        end else if (i_kind == KIND_NULL) begin
                            n_mode  = MODE_IDLE;
                            n_idx   = 3'd0;
                            n_state = S_NULL;
                        end
                    end else if (i_kind == KIND_FMT) begin
                        if (r_mode != MODE_PCT) begin
                            if (i_char == CHAR_PCT) begin
                                n_mode = MODE_PCT;
                            end else begin
                                n_state = S_CHAR;
                            end
                        end else begin
                            n_mode = MODE_IDLE;
                            priority if (i_char == CHAR_D) begin
                                n_cnt   = CW'(NHEX);
                                n_state = S_CONV;
                            end else if (i_char == CHAR_X) begin
                                n_cnt   = CW'(DIG);
                                n_state = S_SKIP;
                            end else if (i_char == CHAR_S) begin
                                n_mode = MODE_STR;
                            end else begin
                                n_pct_count = 1'b0;
                                n_state     = S_PCT;
                            end
                        end
                    end else if (i_kind == KIND_FMT_END) begin
                        n_mode      = MODE_IDLE;
                        n_pct_count = 1'b1;
                        n_state     = (r_mode == MODE_PCT) ? S_PCT : S_COUNT;
                    end
                end
            end
            S_CHAR: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = SRC_INPUT;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_PCT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = SRC_PCT;
                    n_state    = r_pct_count ? S_COUNT : S_CHAR;
                end
            end
            S_COUNT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = SRC_COUNT;
                    o_cmd.last = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            S_NULL: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = SRC_NULL;
                    o_cmd.last = (r_idx == NULL_LAST);
                    n_idx      = r_idx + 3'd1;
                    if (r_idx == NULL_LAST) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_CONV: begin
                o_cmd.step = 1'b1;
                n_cnt      = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_cnt   = CW'(DIG);
                    n_state = i_status.neg ? S_SIGN : S_SKIP;
                end
            end
            S_SIGN: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.src  = SRC_MINUS;
                    n_state    = S_SKIP;
                end
            end
            S_SKIP: begin
                if (i_status.top_zero && r_cnt > CW'(1)) begin
                    o_cmd.shift = 1'b1;
                    n_cnt       = r_cnt - CW'(1);
                end else begin
                    n_state = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit  = 1'b1;
                    o_cmd.src   = SRC_DIGIT;
                    o_cmd.last  = (r_cnt == CW'(1));
                    o_cmd.shift = 1'b1;
                    n_cnt       = r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_IDLE;
            r_cnt       <= '0;
            r_idx       <= '0;
            r_pct_count <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_cnt       <= n_cnt;
            r_idx       <= n_idx;
            r_pct_count <= n_pct_count;
        end
    end

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_status.out_free)
        else $error("result loaded into a full output register");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!o_cmd.emit && !o_cmd.shift && !o_cmd.step))
        else $error("datapath driven while waiting for a request");

    a_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIGIT || r_state == S_CONV || r_state == S_SKIP) |-> (r_cnt != '0))
        else $error("digit counter ran out");

    a_null_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NULL) |-> (r_idx <= NULL_LAST))
        else $error("null text index past end");

endmodule
`default_nettype wire

// ----- tb/tb_format_string_formatter.sv -----
`timescale 1ns / 100ps
module tb_format_string_formatter;
    import fsf_pkg::*;

    localparam logic [2:0] KIND_UNUSED = 3'd7;
    localparam int IDLE_PCT = 18;
    localparam int RANDOM_REQS = 430;

    typedef enum logic [1:0] {
        ST_PLAIN,
        ST_PERCENT,
        ST_STRING
    } fmt_mode_t;

    typedef struct {
        logic [2:0]  kind;
        logic [7:0]  ch;
        logic [31:0] num;
        bit          drain;
    } fmt_req_t;

    typedef struct packed {
        logic [7:0]  ch;
        logic        has_char;
        logic        last;
        logic [30:0] total;
    } out_char_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // char_in[7:0], number[39:8]
    logic [2:0]  s_axis_tuser = '0;   // kind[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // char_out[7:0], total_count[38:8], zero[39]
    logic [0:0]  m_axis_tuser;        // has_char[0]
    logic        m_axis_tlast;

    fmt_req_t  pending_reqs[$];
    out_char_t expected_chars[$];
    fmt_mode_t fmt_mode = ST_PLAIN;
    logic [30:0] char_total = '0;
    int  accepted_reqs = 0;
    int  results_seen = 0;
    int  mismatches = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    bit  drain_next = 1'b0;
    bit  drain_placed = 1'b0;
    wire calm = accepted_reqs >= 320 && accepted_reqs < 380;

    format_string_formatter uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    task automatic put_char(input logic [7:0] c);
        out_char_t r;
        if (char_total != COUNT_MAX) char_total = char_total + 1'b1;
        r.ch = c;
        r.has_char = 1'b1;
        r.last = 1'b0;
        r.total = char_total;
        expected_chars.push_back(r);
    endtask

    task automatic put_decimal(input logic [31:0] num);
        logic [31:0] mag;
        logic [7:0]  digits[$];
        mag = num;
        if (num[31]) begin
            put_char(CHAR_MINUS);
            mag = -num;
        end
        do begin
            digits.push_front(8'h30 + 8'(mag % 10));
            mag = mag / 10;
        end while (mag != 0);
        foreach (digits[i]) put_char(digits[i]);
    endtask

    task automatic put_hex(input logic [31:0] num);
        string       hex_digits;
        logic [31:0] bits;
        logic [7:0]  digits[$];
        hex_digits = "0123456789abcdef";
        bits = num;
        do begin
            digits.push_front(hex_digits[bits[3:0]]);
            bits = bits >> 4;
        end while (bits != 0);
        foreach (digits[i]) put_char(digits[i]);
    endtask

    // update the formatter state for one request and queue the results it produces
    task automatic format_request(input logic [2:0] kind, input logic [7:0] ch,
                                  input logic [31:0] num);
        string     null_text;
        int        first;
        out_char_t r;
        null_text = "(null)";
        first = expected_chars.size();
        if (fmt_mode == ST_STRING) begin
            if (kind == KIND_STR) begin
                put_char(ch);
            end else if (kind == KIND_STR_END) begin
                fmt_mode = ST_PLAIN;
            end else if (kind == KIND_NULL) begin
                for (int i = 0; i < 6; i++) put_char(null_text[i]);
                fmt_mode = ST_PLAIN;
            end
        end else if (kind == KIND_FMT) begin
            if (fmt_mode == ST_PLAIN) begin
                if (ch == CHAR_PCT) fmt_mode = ST_PERCENT;
                else put_char(ch);
            end else begin
                fmt_mode = ST_PLAIN;
                if (ch == CHAR_D) begin
                    put_decimal(num);
                end else if (ch == CHAR_X) begin
                    put_hex(num);
                end else if (ch == CHAR_S) begin
                    fmt_mode = ST_STRING;
                end else begin
                    put_char(CHAR_PCT);
                    put_char(ch);
                end
            end
        end else if (kind == KIND_FMT_END) begin
            if (fmt_mode == ST_PERCENT) put_char(CHAR_PCT);
            r.ch = 8'h00;
            r.has_char = 1'b0;
            r.last = 1'b0;
            r.total = char_total;
            expected_chars.push_back(r);
            char_total = '0;
            fmt_mode = ST_PLAIN;
        end
        if (expected_chars.size() > first) begin
            r = expected_chars.pop_back();
            r.last = 1'b1;
            expected_chars.push_back(r);
        end
    endtask

    task automatic add_req(input logic [2:0] kind, input logic [7:0] ch,
                           input logic [31:0] num);
        fmt_req_t q;
        q.kind = kind;
        q.ch = ch;
        q.num = num;
        q.drain = drain_next;
        drain_next = 1'b0;
        pending_reqs.push_back(q);
    endtask

    function automatic logic [31:0] rand_number();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 99);
            1: return -$urandom_range(1, 99);
            2: return 32'h8000_0000;
            3: return 32'h7fff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_random_format();
        int nsegs;
        int nbytes;
        logic [7:0] c;
        nsegs = $urandom_range(1, 8);
        for (int s = 0; s < nsegs; s++) begin
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    c = 8'($urandom_range(0, 255));
                    if (c == CHAR_PCT) c = "A";
                    add_req(KIND_FMT, c, $urandom);
                end
                3, 4: begin
                    add_req(KIND_FMT, CHAR_PCT, $urandom);
                    add_req(KIND_FMT, CHAR_D, rand_number());
                end
                5: begin
                    add_req(KIND_FMT, CHAR_PCT, $urandom);
                    add_req(KIND_FMT, CHAR_X, rand_number());
                end
                6: begin
                    add_req(KIND_FMT, CHAR_PCT, $urandom);
                    add_req(KIND_FMT, CHAR_S, $urandom);
                    nbytes = $urandom_range(0, 6);
                    for (int i = 0; i < nbytes; i++)
                        add_req(KIND_STR, 8'($urandom_range(0, 255)), $urandom);
                    if ($urandom_range(0, 3) == 0) add_req(KIND_NULL, 8'($urandom), $urandom);
                    else add_req(KIND_STR_END, 8'($urandom), $urandom);
                end
                7: begin
                    add_req(KIND_FMT, CHAR_PCT, $urandom);
                    add_req(KIND_FMT, 8'($urandom_range(0, 255)), rand_number());
                end
                8: add_req(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)), $urandom);
                default: add_req(3'($urandom_range(KIND_STR, KIND_UNUSED)),
                                 8'($urandom_range(0, 255)), $urandom);
            endcase
        end
        if ($urandom_range(0, 7) == 0) add_req(KIND_FMT, CHAR_PCT, $urandom);
        add_req(KIND_FMT_END, 8'($urandom), $urandom);
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                format_request(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[39:8]);
                accepted_reqs <= accepted_reqs + 1;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_reqs.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)
                        && (!pending_reqs[0].drain || expected_chars.size() == 0)) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {pending_reqs[0].num, pending_reqs[0].ch};
                    s_axis_tuser <= pending_reqs[0].kind;
                    pending_reqs.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver, with one long hold-off to back up the block
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!hold_done && results_seen >= 150) begin
            hold_done <= 1'b1;
            hold_left <= 400;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= calm || $urandom_range(99) >= IDLE_PCT;
        end
    end

    task automatic check_field(input string name, input logic [39:0] want,
                               input logic [39:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %h actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        out_char_t want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen <= results_seen + 1;
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected result expected none actual %h/%b/%b", $time,
                         m_axis_tdata, m_axis_tuser, m_axis_tlast);
                mismatches++;
            end else begin
                want = expected_chars.pop_front();
                check_field("char_out", 40'(want.ch), 40'(m_axis_tdata[7:0]));
                check_field("total_count", 40'(want.total), 40'(m_axis_tdata[38:8]));
                check_field("spare bit", 40'(1'b0), 40'(m_axis_tdata[39]));
                check_field("has_char", 40'(want.has_char), 40'(m_axis_tuser[0]));
                check_field("last", 40'(want.last), 40'(m_axis_tlast));
            end
        end
    end

    initial begin
        // plain byte extremes
        add_req(KIND_FMT, 8'h00, 32'h0);
        add_req(KIND_FMT, 8'hff, 32'hffff_ffff);
        // number extremes
        add_req(KIND_FMT, CHAR_PCT, 32'h0);
        add_req(KIND_FMT, CHAR_D, 32'h8000_0000);
        add_req(KIND_FMT, CHAR_PCT, 32'h0);
        add_req(KIND_FMT, CHAR_D, 32'h7fff_ffff);
        add_req(KIND_FMT, CHAR_PCT, 32'h0);
        add_req(KIND_FMT, CHAR_X, 32'hffff_ffff);
        add_req(KIND_FMT, CHAR_PCT, 32'h0);
        add_req(KIND_FMT, CHAR_X, 32'h0);
        // double percent and unknown letter
        add_req(KIND_FMT, CHAR_PCT, 32'h0);
        add_req(KIND_FMT, CHAR_PCT, 32'h0);
        add_req(KIND_FMT, CHAR_PCT, 32'h0);
        add_req(KIND_FMT, "q", 32'h0);
        // wrong kind outside string mode, unused kind
        add_req(KIND_STR, "z", 32'h0);
        add_req(KIND_UNUSED, 8'hff, 32'hffff_ffff);
        // string mode, with format items that must be dropped
        add_req(KIND_FMT, CHAR_PCT, 32'h0);
        add_req(KIND_FMT, CHAR_S, 32'h0);
        add_req(KIND_FMT, "z", 32'h0);
        add_req(KIND_FMT_END, 8'h00, 32'h0);
        add_req(KIND_STR, 8'hff, 32'h0);
        add_req(KIND_STR, 8'h00, 32'h0);
        add_req(KIND_STR_END, 8'h00, 32'h0);
        // null string, then dangling percent at format end
        add_req(KIND_FMT, CHAR_PCT, 32'h0);
        add_req(KIND_FMT, CHAR_S, 32'h0);
        add_req(KIND_NULL, 8'h00, 32'h0);
        add_req(KIND_FMT, CHAR_PCT, 32'h0);
        add_req(KIND_FMT_END, 8'h00, 32'h0);
        while (pending_reqs.size() < RANDOM_REQS) begin
            if (!drain_placed && pending_reqs.size() >= 250) begin
                drain_next = 1'b1;
                drain_placed = 1'b1;
            end
            add_random_format();
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || s_axis_tvalid || expected_chars.size() != 0)
            @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (mismatches == 0 && expected_chars.size() == 0)
            $display("tb_format_string_formatter passed");
        else
            $display("tb_format_string_formatter failed");
        $finish;
    end

    initial begin
        #3_000_000;
        $display("tb_format_string_formatter failed");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/fsf_pkg.sv
rtl/core/fsf_datapath.sv
rtl/core/fsf_ctrl.sv
rtl/core/format_string_formatter.sv
tb/tb_format_string_formatter.sv
